[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the sorted list block.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SLI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Checks that a trigger implies a consequence in the same cycle.
`define SLI_ASSERT_IMPLIES(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error(msg);

`endif

[hdl/sli_pkg.sv]
// Package of the sorted list block: default sizes, codes and the cell control struct.
// Used by sli_cell and sorted_list_insert_delete; depends on nothing.
package sli_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int IN_VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH    = 2;
    localparam int COUNT_WIDTH     = 5;
    localparam int SMALLEST_WIDTH  = 32;
    localparam int RESULT_WIDTH    = STATUS_WIDTH + COUNT_WIDTH + SMALLEST_WIDTH + 1;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } kind_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    // Command broadcast to every cell in the update cycle.
    typedef struct packed {
        logic apply;   // cells change their contents this cycle
        logic insert;  // 1: make room and place the value, 0: close the gap
    } sli_ctl_t;

endpackage

[hdl/sli_cell.sv]
// One cell of the sorted list: a stored value, its valid bit and its compare flags.
// Depends on sli_pkg for the control struct and the default value width.
module sli_cell #(
    parameter int VALUE_WIDTH = sli_pkg::DEF_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cmp_en,
    input  logic [VALUE_WIDTH-1:0] cmp_value,
    input  sli_pkg::sli_ctl_t      ctl,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic                   left_lt,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic                   left_valid,
    input  logic [VALUE_WIDTH-1:0] right_value,
    input  logic                   right_valid,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   valid,
    output logic                   lt,
    output logic                   hit
);

    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                   valid_reg, valid_next;
    logic                   lt_reg;
    logic                   eq_reg;

    // Entries below the operation point keep their place; the rest move.
    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.apply && !lt_reg) begin
            if (ctl.insert) begin
                if (left_lt) begin
                    value_next = new_value;
                    valid_next = 1'b1;
                end else begin
                    value_next = left_value;
                    valid_next = left_valid;
                end
            end else begin
                value_next = right_value;
                valid_next = right_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmp_en) begin
                lt_reg <= valid_reg && ($signed(value_reg) < $signed(cmp_value));
                eq_reg <= valid_reg && (value_reg == cmp_value);
            end
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    // The first entry not below the value is the one a delete removes.
    assign hit   = eq_reg && left_lt;

endmodule

[hdl/sorted_list_insert_delete.sv]
// Top level of the sorted list: handshake, operation control and a row of sli_cell.
// Depends on sli_pkg, sli_cell and assert_macros.svh.
//
//  channel  | ports           | tdata (low bit up)                       | tuser
//  ---------+-----------------+------------------------------------------+-------
//  input    | s_tvalid/tready | value[31:0]                              | kind
//  result   | m_tvalid/tready | status[1:0] entry_count[6:2]             | -
//           |                 | smallest[38:7] is_empty[39]              |
//
// At acceptance of an item every cell registers whether its entry is below and equal to
// the item's value; in the APPLY state that follows, once the result register is free, the cells
// from the operation point onward shift by one place (right for an insert, left for a delete)
// and the result item is registered. The compare flags are held in a register in every cell.
// Reset clears the count, all valid bits and the result valid flag; no clearing pass.
// A stalled result holds the update until the result register is free; no new item
// is accepted while an update is pending.

`include "assert_macros.svh"

module sorted_list_insert_delete #(
    parameter int CAPACITY    = sli_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = sli_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sli_pkg::IN_VALUE_WIDTH-1:0] s_tdata,   // value
    input  logic                              s_tuser,   // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sli_pkg::RESULT_WIDTH-1:0]  m_tdata    // status, entry_count, smallest,
                                                         // is_empty
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int CW_EXT = (CW > sli_pkg::COUNT_WIDTH) ? CW : sli_pkg::COUNT_WIDTH;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t                 state_reg;
    logic                   kind_reg;
    logic [VALUE_WIDTH-1:0] op_value_reg;
    logic [CW-1:0]          count_reg;
    logic                   m_tvalid_reg;
    logic [sli_pkg::RESULT_WIDTH-1:0] m_tdata_reg;

    logic [VALUE_WIDTH-1:0] in_value;
    logic                   s_accept;
    logic                   out_free;
    logic                   full;
    logic                   found;
    logic                   do_update;
    sli_pkg::sli_ctl_t      ctl;

    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]    cell_valid;
    logic [CAPACITY-1:0]    cell_lt;
    logic [CAPACITY-1:0]    cell_hit;

    logic [CW-1:0]          count_next;
    logic [VALUE_WIDTH-1:0] head_next;
    logic [63:0]            head_ext;
    logic [CW_EXT-1:0]      count_ext;
    sli_pkg::status_t       status;
    logic                   empty_next;
    logic [sli_pkg::SMALLEST_WIDTH-1:0] smallest_next;

    // The 32-bit field wraps into the stored width with sign extension.
    logic [63:0] in_ext;
    assign in_ext   = 64'(signed'(s_tdata));
    assign in_value = in_ext[VALUE_WIDTH-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign found    = |cell_hit;

    // An insert into a full row and a delete that misses leave the cells alone.
    always_comb begin
        do_update  = (state_reg == ST_APPLY) && out_free;
        ctl.insert = (kind_reg == sli_pkg::KIND_INSERT);
        ctl.apply  = do_update && (ctl.insert ? !full : found);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                   l_lt;
            logic [VALUE_WIDTH-1:0] l_value;
            logic                   l_valid;
            logic [VALUE_WIDTH-1:0] r_value;
            logic                   r_valid;

            if (gi == 0) begin : g_head
                // The head has an imaginary smaller neighbor, so it takes the new value.
                assign l_lt    = 1'b1;
                assign l_value = '0;
                assign l_valid = 1'b0;
            end else begin : g_body
                assign l_lt    = cell_lt[gi-1];
                assign l_value = cell_value[gi-1];
                assign l_valid = cell_valid[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign r_value = '0;
                assign r_valid = 1'b0;
            end else begin : g_inner
                assign r_value = cell_value[gi+1];
                assign r_valid = cell_valid[gi+1];
            end

            sli_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmp_en      (s_accept),
                .cmp_value   (in_value),
                .ctl         (ctl),
                .new_value   (op_value_reg),
                .left_lt     (l_lt),
                .left_value  (l_value),
                .left_valid  (l_valid),
                .right_value (r_value),
                .right_valid (r_valid),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .lt          (cell_lt[gi]),
                .hit         (cell_hit[gi])
            );
        end
    endgenerate

    // Result of the pending operation, worked out from the flags and the current head.
    always_comb begin
        count_next = count_reg;
        head_next  = cell_value[0];
        status     = sli_pkg::STATUS_DONE;
        if (ctl.insert) begin
            if (full) begin
                status = sli_pkg::STATUS_FULL;
            end else begin
                count_next = count_reg + CW'(1);
                head_next  = cell_lt[0] ? cell_value[0] : op_value_reg;
            end
        end else begin
            if (!found) begin
                status = sli_pkg::STATUS_NOT_FOUND;
            end else begin
                count_next = count_reg - CW'(1);
                head_next  = cell_lt[0] ? cell_value[0] : cell_value[1];
            end
        end
        empty_next    = (count_next == '0);
        head_ext      = 64'(signed'(head_next));
        smallest_next = empty_next ? '0 : head_ext[sli_pkg::SMALLEST_WIDTH-1:0];
        count_ext     = CW_EXT'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg     <= s_tuser;
            op_value_reg <= in_value;
        end
        if (do_update) begin
            m_tdata_reg <= {empty_next, smallest_next,
                            count_ext[sli_pkg::COUNT_WIDTH-1:0], status};
        end
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (do_update) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The valid bits in the row always agree with the count.
    `SLI_ASSERT_ALWAYS(a_count_matches_cells, ($countones(cell_valid) == 32'(count_reg)),
        "valid cells disagree with the stored count")
    // The below-value flags form a prefix of the row.
    `SLI_ASSERT_IMPLIES(a_lt_prefix, (state_reg == ST_APPLY),
        (((cell_lt + CAPACITY'(1)) & cell_lt) == '0),
        "compare flags are not a prefix of the row")
    // At most one cell claims the copy a delete removes.
    `SLI_ASSERT_IMPLIES(a_single_hit, (state_reg == ST_APPLY), $onehot0(cell_hit),
        "more than one cell matched a delete")
    // A new result only appears after an update cycle.
    `SLI_ASSERT_IMPLIES(a_result_after_update, $rose(m_tvalid_reg),
        ($past(state_reg) == ST_APPLY), "result raised without an update")

endmodule
